>>> hdl/drvil_pkg.sv
package drvil_pkg;

	// Stream widths, padded to whole bytes, then the unpadded command and result widths.
	localparam int IN_TDATA_W  = 88;
	localparam int OUT_TDATA_W = 24;
	localparam int CMD_W       = 51;
	localparam int RES_W       = 19;

	// Field widths.
	localparam int SPEED_W = 14;
	localparam int LIMIT_W = 16;
	localparam int TIME_W  = 32;
	localparam int CFG_W   = 16;

	localparam logic [SPEED_W-1:0] SPEED_MAX = 14'd10000;

	// Register reset values.
	localparam logic [LIMIT_W-1:0] STALE_LIMIT_RST = 16'd500;
	localparam logic [SPEED_W-1:0] HOLD_RST        = 14'd100;
	localparam logic [SPEED_W-1:0] RAMP_RST        = 14'd200;

	// Owner encoding.
	typedef enum logic [1:0] {
		OWNER_NONE     = 2'd0,
		OWNER_RC       = 2'd1,
		OWNER_DIRECT   = 2'd2,
		OWNER_JOYSTICK = 2'd3
	} owner_t;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		CFG_STALE_LIMIT = 2'd0,
		CFG_HOLD        = 2'd1,
		CFG_RAMP        = 2'd2
	} cfg_idx_t;

	// Command snapshot, packed exactly as the low bits of the input word.
	typedef struct packed {
		logic [TIME_W-1:0] stamp;
		logic signed [14:0] throttle;
		logic               reverse;
		logic [1:0]         owner;
		logic               enable;
	} cmd_t;

	// Result word, packed exactly as the output word.
	typedef struct packed {
		logic               stale;
		logic               handover;
		logic [1:0]         owner;
		logic               reverse;
		logic [SPEED_W-1:0] speed;
	} res_t;

	// Configuration register set.
	typedef struct packed {
		logic [LIMIT_W-1:0] stale_limit;
		logic [SPEED_W-1:0] hold;
		logic [SPEED_W-1:0] ramp;
	} cfg_t;

endpackage

>>> hdl/drive_interlock_ramp.sv
// Drive interlock and speed ramp. Each input word is one control tick: a command snapshot
// with its stable flag and the current time. The block takes one word per clock cycle
// back to back while its results are taken; a stalled result slot holds the input. The
// word goes through the input register, then the single state-update stage into the
// result register, where it is presented. That state update is what sets the rate. A
// stale, unstamped or disabled command ramps the speed to zero. Owner handovers and
// reversals commit only at or below the hold threshold. The user must write registers
// through cfg_we/cfg_index/cfg_data only while the block is idle, which the block itself
// does not enforce. Index 3 is ignored. No clearing pass is needed after reset.
module drive_interlock_ramp (
	input  logic                             clk,
	input  logic                             arst_n,
	// Input stream.
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// tdata from bit 0: cmd_enable, cmd_owner[1:0], cmd_reverse, cmd_throttle[14:0],
	// cmd_stamp_ms[31:0], now_ms[31:0], zero pad.
	input  logic [drvil_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	// tuser: snapshot_stable.
	input  logic [0:0]                       s_axis_tuser,
	// Output stream.
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// tdata from bit 0: speed_out[13:0], reverse_out, owner_out[1:0], handover_out,
	// stale_out, zero pad.
	output logic [drvil_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	// Configuration write port.
	input  logic                             cfg_we,
	input  logic [1:0]                       cfg_index,
	input  logic [drvil_pkg::CFG_W-1:0]       cfg_data
);
	import drvil_pkg::*;

	cfg_t               cfg_q;
	logic               v_s1;
	logic               adv;
	logic               load;
	logic               out_valid_q;
	cmd_t               cmd;
	logic [TIME_W-1:0]  now_ms;
	res_t               res_s2;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.stale_limit <= STALE_LIMIT_RST;
			cfg_q.hold        <= HOLD_RST;
			cfg_q.ramp        <= RAMP_RST;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_STALE_LIMIT: cfg_q.stale_limit <= cfg_data;
				CFG_HOLD:        cfg_q.hold        <= cfg_data[SPEED_W-1:0];
				CFG_RAMP:        cfg_q.ramp        <= cfg_data[SPEED_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Handshake: the word in the input register moves on when the result slot is free or its result is being taken.
	assign adv           = v_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !v_s1 || adv;
	assign load          = s_axis_tvalid && s_axis_tready;

	drvil_snap u_snap (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (load),
		.tdata  (s_axis_tdata),
		.stable (s_axis_tuser[0]),
		.adv    (adv),
		.v_s1   (v_s1),
		.cmd    (cmd),
		.now_ms (now_ms)
	);

	drvil_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.cmd    (cmd),
		.now_ms (now_ms),
		.cfg    (cfg_q),
		.res_s2 (res_s2)
	);

	// Result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_TDATA_W-RES_W){1'b0}}, res_s2};

	// The speed never leaves 0..10000.
	a_speed_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (res_s2.speed <= SPEED_MAX))
		else $error("speed out of range");

	// A word that advances always yields a result on the next cycle.
	a_adv_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> m_axis_tvalid)
		else $error("advanced word produced no result");

	// With the result slot empty the block always takes input.
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> s_axis_tready)
		else $error("input stalled with empty result slot");

endmodule

>>> hdl/drvil_snap.sv
module drvil_snap (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            load,
	input  logic [drvil_pkg::IN_TDATA_W-1:0] tdata,
	input  logic                            stable,
	input  logic                            adv,
	output logic                            v_s1,
	output drvil_pkg::cmd_t                 cmd,
	output logic [drvil_pkg::TIME_W-1:0]    now_ms
);
	import drvil_pkg::*;

	logic [IN_TDATA_W-1:0] data_s1;
	logic                  stable_s1;
	cmd_t                  saved_q;
	logic                  have_saved_q;
	cmd_t                  cmd_in;

	// Input register; payload carries no reset.
	always_ff @(posedge clk) begin
		if (load) begin
			data_s1   <= tdata;
			stable_s1 <= stable;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (load) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	assign cmd_in = cmd_t'(data_s1[CMD_W-1:0]);
	assign now_ms = data_s1[CMD_W+TIME_W-1:CMD_W];

	// Keep the last consistently read snapshot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			saved_q      <= '0;
			have_saved_q <= 1'b0;
		end else if (adv && stable_s1) begin
			saved_q      <= cmd_in;
			have_saved_q <= 1'b1;
		end
	end

	// Pick the command in use: fresh, saved, or a disabled one stamped now.
	always_comb begin
		if (stable_s1) begin
			cmd = cmd_in;
		end else if (have_saved_q) begin
			cmd = saved_q;
		end else begin
			cmd       = '0;
			cmd.stamp = now_ms;
		end
	end

endmodule

>>> hdl/drvil_ctrl.sv
module drvil_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         adv,
	input  drvil_pkg::cmd_t              cmd,
	input  logic [drvil_pkg::TIME_W-1:0] now_ms,
	input  drvil_pkg::cfg_t              cfg,
	output drvil_pkg::res_t              res_s2
);
	import drvil_pkg::*;

	logic [1:0]         owner_q;
	logic [1:0]         pending_q;
	logic               waiting_q;
	logic               reverse_q;
	logic [SPEED_W-1:0] speed_q;

	logic [TIME_W-1:0]  age;
	logic               stale;
	logic               en;
	logic [1:0]         req_owner;
	logic               slow;
	logic [1:0]         owner_a;
	logic [1:0]         owner_c;
	logic [1:0]         pending_b;
	logic [1:0]         pending_c;
	logic               waiting_b;
	logic               waiting_c;
	logic               pass;
	logic               req_dir;
	logic               reverse_n;
	logic [SPEED_W-1:0] clamped;
	logic [SPEED_W-1:0] target;
	logic [SPEED_W:0]   sum;
	logic [SPEED_W-1:0] diff;
	logic [SPEED_W-1:0] speed_n;

	// Command age and enable.
	assign age   = now_ms - cmd.stamp;
	assign stale = (cmd.stamp == '0) || (age > {{(TIME_W-LIMIT_W){1'b0}}, cfg.stale_limit});
	assign en    = !stale && cmd.enable;
	assign req_owner = en ? cmd.owner : owner_q;
	assign slow  = speed_q <= cfg.hold;

	// Owner claim, handover request and handover commit, in that order.
	always_comb begin
		owner_a = owner_q;
		if (en && !waiting_q && owner_q == OWNER_NONE && req_owner != OWNER_NONE && slow) begin
			owner_a = req_owner;
		end

		pending_b = pending_q;
		waiting_b = waiting_q;
		if (en && req_owner != OWNER_NONE && req_owner != owner_a && !slow) begin
			pending_b = req_owner;
			waiting_b = 1'b1;
		end

		owner_c   = owner_a;
		pending_c = pending_b;
		waiting_c = waiting_b;
		if (waiting_b && slow) begin
			owner_c   = pending_b;
			pending_c = OWNER_NONE;
			waiting_c = 1'b0;
		end
	end

	// Throttle clamp to 0..10000.
	always_comb begin
		if (cmd.throttle < 0) begin
			clamped = '0;
		end else if (cmd.throttle[13:0] > SPEED_MAX || cmd.throttle[14]) begin
			clamped = SPEED_MAX;
		end else begin
			clamped = cmd.throttle[SPEED_W-1:0];
		end
	end

	// Target and direction; a reversal forces the target to zero.
	always_comb begin
		pass      = en && !waiting_c;
		req_dir   = pass ? cmd.reverse : reverse_q;
		target    = pass ? clamped : '0;
		reverse_n = reverse_q;
		if (req_dir != reverse_q) begin
			target = '0;
			if (slow) begin
				reverse_n = req_dir;
			end
		end
	end

	// Ramp toward the target without overshoot; the target bounds the result to 10000.
	always_comb begin
		sum  = {1'b0, speed_q} + {1'b0, cfg.ramp};
		diff = speed_q - target;
		if (speed_q < target) begin
			speed_n = (sum > {1'b0, target}) ? target : sum[SPEED_W-1:0];
		end else if (speed_q > target) begin
			speed_n = (diff > cfg.ramp) ? speed_q - cfg.ramp : target;
		end else begin
			speed_n = speed_q;
		end
	end

	// Drive state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owner_q   <= OWNER_NONE;
			pending_q <= OWNER_NONE;
			waiting_q <= 1'b0;
			reverse_q <= 1'b0;
			speed_q   <= '0;
		end else if (adv) begin
			owner_q   <= owner_c;
			pending_q <= pending_c;
			waiting_q <= waiting_c;
			reverse_q <= reverse_n;
			speed_q   <= speed_n;
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2.speed    <= speed_n;
			res_s2.reverse  <= reverse_n;
			res_s2.owner    <= owner_c;
			res_s2.handover <= waiting_c;
			res_s2.stale    <= stale;
		end
	end

endmodule
